FILE: rtl/lr_pkg.sv
// Package for the line rasteriser: word types, the line descriptor and the stepper states.
// Every module of the line rasteriser imports it; it depends on nothing else.
package lr_pkg;

	// Fixed port widths of the coordinate and colour fields.
	localparam int COORD_W = 6;
	localparam int COLOR_W = 24;

	// Default number of coordinate bits that take part in drawing.
	localparam int COORD_BITS_DEF = 6;

	// Depth of the descriptor and pixel queues.
	localparam int QUEUE_DEPTH = 2;

	// One input word: a line given by two endpoints and a colour.
	typedef struct packed {
		logic [COORD_W-1:0] x_a;
		logic [COORD_W-1:0] y_a;
		logic [COORD_W-1:0] x_b;
		logic [COORD_W-1:0] y_b;
		logic [COLOR_W-1:0] color;
	} line_t;

	// One output word: a single pixel of a line.
	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [COLOR_W-1:0] pixel_color;
		logic               last_pixel;
	} pixel_t;

	// A classified line, ready for the stepper.
	typedef struct packed {
		logic               major_x;
		logic               neg;
		logic [COORD_W-1:0] s_maj;
		logic [COORD_W-1:0] s_min;
		logic [COORD_W-1:0] dmaj;
		logic [COORD_W-1:0] adm;
		logic [COLOR_W-1:0] color;
	} desc_t;

	// Stepper states.
	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

endpackage

FILE: rtl/line_rasterizer_core.sv
// Line rasteriser top level: front end, descriptor queue, stepper and pixel queue.
// Depends on lr_pkg, lr_front, lr_queue and lr_back.
//
// Each input word is a line between two endpoints with a colour; the block returns one word per
// pixel, stepping one unit along the axis with the larger span (y on a tie), the last pixel
// flagged. A line whose major span is n gives n + 1 pixels, so up to 2^COORD_BITS pixels; the
// stepper first takes the classified line and then makes its pixels. The single stepper in the
// back end makes one pixel per cycle while the pixel queue has room. The front end classifies
// a line in the cycle it is pushed; a two-word queue lets up to two classified lines wait while
// the stepper works, and a two-word pixel queue holds results while pop is low. Coincident
// endpoints give a single pixel.
module line_rasterizer_core #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lr_pkg::line_t  line,
	output logic           full,
	input  logic           pop,
	output lr_pkg::pixel_t pixel,
	output logic           empty
);
	import lr_pkg::*;

	desc_t  desc_in;
	desc_t  desc_head;
	logic   desc_empty;
	logic   desc_pop;
	pixel_t pixel_next;
	logic   pixel_full;
	logic   pixel_push;

	// Classify the incoming line.
	lr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.line(line),
		.desc(desc_in)
	);

	// Classified lines waiting for the stepper.
	lr_queue #(
		.T(desc_t),
		.DEPTH(QUEUE_DEPTH)
	) u_desc_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(desc_in),
		.full(full),
		.pop(desc_pop),
		.rdata(desc_head),
		.empty(desc_empty)
	);

	// Step along the line.
	lr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.desc(desc_head),
		.desc_empty(desc_empty),
		.desc_pop(desc_pop),
		.pixel(pixel_next),
		.pixel_full(pixel_full),
		.pixel_push(pixel_push)
	);

	// Pixels waiting to be taken.
	lr_queue #(
		.T(pixel_t),
		.DEPTH(QUEUE_DEPTH)
	) u_pixel_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(pixel_push),
		.wdata(pixel_next),
		.full(pixel_full),
		.pop(pop),
		.rdata(pixel),
		.empty(empty)
	);

endmodule

FILE: rtl/lr_queue.sv
// Small first-in first-out queue of packed words, used between the parts of the rasteriser.
// Depends on lr_pkg for the default depth.
module lr_queue #(
	parameter type T     = logic,
	parameter int  DEPTH = lr_pkg::QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);
	import lr_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T              mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	// A push is taken only when there is room, a pop only when a word is held.
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage is written at the tail pointer.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: rtl/lr_front.sv
// Front end of the rasteriser: reduces the endpoints to the drawing width and classifies the line.
// Depends on lr_pkg for the word and descriptor types.
module lr_front #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
	input  lr_pkg::line_t line,
	output lr_pkg::desc_t desc
);
	import lr_pkg::*;

	localparam logic [COORD_W-1:0] MASK = COORD_W'((1 << COORD_BITS) - 1);

	logic [COORD_W-1:0] ax, ay, bx, by;
	logic [COORD_W-1:0] dx, dy;
	logic [COORD_W-1:0] sx, sy, ex, ey;
	logic [COORD_W-1:0] s_maj, e_maj, s_min, e_min;
	logic               major_x;
	logic               first_a;
	logic               neg;

	always_comb begin
		// Only the low coordinate bits take part.
		ax = line.x_a & MASK;
		ay = line.y_a & MASK;
		bx = line.x_b & MASK;
		by = line.y_b & MASK;

		// Spans on both axes; a tie makes y the major axis.
		dx      = (ax < bx) ? (bx - ax) : (ax - bx);
		dy      = (ay < by) ? (by - ay) : (ay - by);
		major_x = (dx > dy);

		// The endpoint with the smaller major coordinate starts the line.
		first_a = major_x ? (ax < bx) : (ay < by);
		sx      = first_a ? ax : bx;
		sy      = first_a ? ay : by;
		ex      = first_a ? bx : ax;
		ey      = first_a ? by : ay;

		s_maj = major_x ? sx : sy;
		e_maj = major_x ? ex : ey;
		s_min = major_x ? sy : sx;
		e_min = major_x ? ey : ex;

		// The minor delta is kept as magnitude and direction.
		neg = (e_min < s_min);

		desc.major_x = major_x;
		desc.neg     = neg;
		desc.s_maj   = s_maj;
		desc.s_min   = s_min;
		desc.dmaj    = e_maj - s_maj;
		desc.adm     = neg ? (s_min - e_min) : (e_min - s_min);
		desc.color   = line.color;
	end

endmodule

FILE: rtl/lr_back.sv
// Back end: steps on the major axis, one pixel per cycle while the pixel queue has room.
// Depends on lr_pkg for the descriptor, pixel and state types.
module lr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  lr_pkg::desc_t desc,
	input  logic          desc_empty,
	output logic          desc_pop,
	output lr_pkg::pixel_t pixel,
	input  logic          pixel_full,
	output logic          pixel_push
);
	import lr_pkg::*;

	back_state_t        state_q, state_d;
	logic               major_x_q;
	logic               neg_q;
	logic [COORD_W-1:0] mj_q;
	logic [COORD_W-1:0] mn_q;
	logic [COORD_W-1:0] off_q;
	logic [COORD_W-1:0] dmaj_q;
	logic [COORD_W-1:0] adm_q;
	logic [COORD_W-1:0] rem_q;
	logic [COLOR_W-1:0] color_q;
	logic [COORD_W:0]   rem_sum;
	logic               carry;
	logic [COORD_W-1:0] rem_d;
	logic               last;

	// The remainder grows by the minor span each step and moves the minor coordinate
	// by one whenever it reaches the major span, which gives the truncated quotient.
	always_comb begin
		rem_sum = {1'b0, rem_q} + {1'b0, adm_q};
		carry   = (rem_sum >= {1'b0, dmaj_q});
		rem_d   = carry ? COORD_W'(rem_sum - {1'b0, dmaj_q}) : COORD_W'(rem_sum);
		last    = (off_q == dmaj_q);
	end

	// Current pixel, with the axes put back in place.
	always_comb begin
		pixel.pixel_x     = major_x_q ? mj_q : mn_q;
		pixel.pixel_y     = major_x_q ? mn_q : mj_q;
		pixel.pixel_color = color_q;
		pixel.last_pixel  = last;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshakes: load a descriptor when idle, then emit until the last pixel.
	always_comb begin
		state_d    = state_q;
		desc_pop   = 1'b0;
		pixel_push = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!desc_empty) begin
					desc_pop = 1'b1;
					state_d  = BK_RUN;
				end
			end
			BK_RUN: begin
				if (!pixel_full) begin
					pixel_push = 1'b1;
					if (last) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Stepper datapath.
	always_ff @(posedge clk) begin
		if (desc_pop) begin
			major_x_q <= desc.major_x;
			neg_q     <= desc.neg;
			mj_q      <= desc.s_maj;
			mn_q      <= desc.s_min;
			off_q     <= '0;
			dmaj_q    <= desc.dmaj;
			adm_q     <= desc.adm;
			rem_q     <= '0;
			color_q   <= desc.color;
		end else if (pixel_push && !last) begin
			mj_q  <= mj_q + COORD_W'(1);
			off_q <= off_q + COORD_W'(1);
			rem_q <= rem_d;
			if (carry) begin
				mn_q <= neg_q ? (mn_q - COORD_W'(1)) : (mn_q + COORD_W'(1));
			end
		end
	end

endmodule

FILE: rtl/lr_checker.sv
// Port-level checks for the line rasteriser and the bind that attaches them to the top level.
// Depends on lr_pkg and line_rasterizer_core.
module lr_checker #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	input logic           full,
	input logic           pop,
	input lr_pkg::pixel_t pixel,
	input logic           empty
);
	import lr_pkg::*;

	// While reset is held the pixel queue is empty and the line queue is not full.
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("queues not empty during reset");

	// A waiting word that is not taken stays as it is.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(pixel)))
		else $error("waiting pixel changed before it was taken");

	// A pixel never leaves the drawing area.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((32'(pixel.pixel_x) >> COORD_BITS) == 0 &&
		            (32'(pixel.pixel_y) >> COORD_BITS) == 0))
		else $error("pixel outside the drawing area");

	// The pixel after a non-final one is a neighbour of it and has the same colour.
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !pixel.last_pixel) ##1 !empty |->
		(pixel.pixel_color == $past(pixel.pixel_color) &&
		 (pixel.pixel_x == $past(pixel.pixel_x) ||
		  pixel.pixel_x == $past(pixel.pixel_x) + COORD_W'(1) ||
		  pixel.pixel_x + COORD_W'(1) == $past(pixel.pixel_x)) &&
		 (pixel.pixel_y == $past(pixel.pixel_y) ||
		  pixel.pixel_y == $past(pixel.pixel_y) + COORD_W'(1) ||
		  pixel.pixel_y + COORD_W'(1) == $past(pixel.pixel_y)) &&
		 !(pixel.pixel_x == $past(pixel.pixel_x) && pixel.pixel_y == $past(pixel.pixel_y))))
		else $error("consecutive pixels of a line are not neighbours");

endmodule

bind line_rasterizer_core lr_checker #(
	.COORD_BITS(COORD_BITS)
) u_lr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.full(full),
	.pop(pop),
	.pixel(pixel),
	.empty(empty)
);
